[rtl/pdr_pkg.sv]
// Package for the point decimator and rotator: widths, register indexes,
// reset values and the stage control struct. No dependencies.
package pdr_pkg;

	localparam int COORD_WIDTH    = 32;
	localparam int PAYLOAD_WIDTH  = 64;
	localparam int STRIDE_WIDTH   = 16;
	localparam int COEF_BITS      = 18;
	localparam int ROW_BITS       = 3 * COEF_BITS;
	localparam int FRAC_BITS      = 16;
	localparam int CFG_INDEX_BITS = 3;
	localparam int PROD_BITS      = COORD_WIDTH + COEF_BITS;
	localparam int SUM_BITS       = PROD_BITS + 2;
	localparam int RND_BITS       = SUM_BITS - FRAC_BITS;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_STRIDE    = 3'd0,
		CFG_ROW_X     = 3'd1,
		CFG_ROW_Y     = 3'd2,
		CFG_ROW_Z     = 3'd3,
		CFG_ROTATE_EN = 3'd4
	} cfg_index_t;

	localparam logic [COEF_BITS-1:0] COEF_ONE  = COEF_BITS'(1 << FRAC_BITS);
	localparam logic [COEF_BITS-1:0] COEF_ZERO = '0;

	localparam logic [ROW_BITS-1:0] ROW_X_IDENT = {COEF_ZERO, COEF_ZERO, COEF_ONE};
	localparam logic [ROW_BITS-1:0] ROW_Y_IDENT = {COEF_ZERO, COEF_ONE, COEF_ZERO};
	localparam logic [ROW_BITS-1:0] ROW_Z_IDENT = {COEF_ONE, COEF_ZERO, COEF_ZERO};

	localparam logic [STRIDE_WIDTH-1:0] STRIDE_RESET = STRIDE_WIDTH'(1);

	// Load strobes for the two registered stages inside a matrix row.
	typedef struct packed {
		logic load_s2;
		logic load_out;
	} pdr_ctl_t;

endpackage

[rtl/point_decimate_rotate.sv]
// Top level of the point decimator and rotator: phase counter, config
// registers, pipeline control and three matrix rows. Depends on pdr_pkg, pdr_row.
//
// Usage: points enter on the input channel (in_valid / in_stall with
// cloud_start, x_in, y_in, z_in, payload_in) and kept points leave on the
// output channel (out_valid / out_stall with x_out, y_out, z_out, payload_out).
// A point with cloud_start set restarts the phase; the first point of a cloud
// is kept, then every stride-th point. Dropped points produce no transfer.
// A kept point passes from the input transfer into the input register, then
// through the coordinate-by-coefficient multipliers into the product register,
// then through the three-term sum with rounding and saturation into the output register.
// Throughput is one point per cycle unless the receiver stalls; then the output
// register holds its result and the two inner stages keep filling; in_stall rises
// only once all three are full. Reset clears the phase, the valid flags and loads
// the identity matrix, stride 1 and rotation enabled. Configuration is written through
// cfg_write_en / cfg_index / cfg_data while no point is in flight.
module point_decimate_rotate (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_write_en,
	input  logic [pdr_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
	input  logic [pdr_pkg::ROW_BITS-1:0]             cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     cloud_start,
	input  logic signed [pdr_pkg::COORD_WIDTH-1:0]   x_in,
	input  logic signed [pdr_pkg::COORD_WIDTH-1:0]   y_in,
	input  logic signed [pdr_pkg::COORD_WIDTH-1:0]   z_in,
	input  logic [pdr_pkg::PAYLOAD_WIDTH-1:0]        payload_in,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [pdr_pkg::COORD_WIDTH-1:0]   x_out,
	output logic signed [pdr_pkg::COORD_WIDTH-1:0]   y_out,
	output logic signed [pdr_pkg::COORD_WIDTH-1:0]   z_out,
	output logic [pdr_pkg::PAYLOAD_WIDTH-1:0]        payload_out
);
	import pdr_pkg::*;

	logic [STRIDE_WIDTH-1:0] stride_q;
	logic [ROW_BITS-1:0]     row_x_q, row_y_q, row_z_q;
	logic                    rotate_q;
	logic [STRIDE_WIDTH-1:0] phase_q;

	logic [STRIDE_WIDTH-1:0] eff_stride;
	logic [STRIDE_WIDTH-1:0] phase_base;
	logic [STRIDE_WIDTH-1:0] phase_inc;
	logic [STRIDE_WIDTH-1:0] phase_next;
	logic                    keep;
	logic                    in_xfer;

	logic                    v_s1, v_s2, out_valid_q;
	logic                    ready_out, ready_s2, ready_s1;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1, z_s1;
	logic                    rot_s1;
	logic [PAYLOAD_WIDTH-1:0] payload_s1, payload_s2, payload_q;
	logic [ROW_BITS-1:0]     cx, cy, cz;
	pdr_ctl_t                ctl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= STRIDE_RESET;
			row_x_q  <= ROW_X_IDENT;
			row_y_q  <= ROW_Y_IDENT;
			row_z_q  <= ROW_Z_IDENT;
			rotate_q <= 1'b1;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_STRIDE:    stride_q <= cfg_data[STRIDE_WIDTH-1:0];
				CFG_ROW_X:     row_x_q  <= cfg_data;
				CFG_ROW_Y:     row_y_q  <= cfg_data;
				CFG_ROW_Z:     row_z_q  <= cfg_data;
				CFG_ROTATE_EN: rotate_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Phase decision happens at the input transfer; dropped points never
	// enter the pipeline.
	assign eff_stride = (stride_q == '0) ? STRIDE_RESET : stride_q;
	assign phase_base = cloud_start ? '0 : phase_q;
	assign keep       = (phase_base == '0);
	assign phase_inc  = phase_base + STRIDE_WIDTH'(1);
	assign phase_next = (phase_inc >= eff_stride) ? '0 : phase_inc;

	assign ready_out = !out_valid_q || !out_stall;
	assign ready_s2  = !v_s2 || ready_out;
	assign ready_s1  = !v_s1 || ready_s2;
	assign in_stall  = !ready_s1;
	assign in_xfer   = in_valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				phase_q <= phase_next;
			end
			if (ready_s1) begin
				v_s1 <= in_xfer && keep;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && keep) begin
			x_s1       <= x_in;
			y_s1       <= y_in;
			z_s1       <= z_in;
			rot_s1     <= rotate_q;
			payload_s1 <= payload_in;
		end
		if (ctl.load_s2) begin
			payload_s2 <= payload_s1;
		end
		if (ctl.load_out) begin
			payload_q <= payload_s2;
		end
	end

	assign ctl.load_s2  = ready_s2 && v_s1;
	assign ctl.load_out = ready_out && v_s2;

	// With rotation off the identity matrix is applied; multiplying by 1.0 and
	// rounding returns each coordinate exactly, so no bypass path is needed.
	assign cx = rot_s1 ? row_x_q : ROW_X_IDENT;
	assign cy = rot_s1 ? row_y_q : ROW_Y_IDENT;
	assign cz = rot_s1 ? row_z_q : ROW_Z_IDENT;

	pdr_row u_row_x (
		.clk   (clk),
		.ctl   (ctl),
		.x     (x_s1),
		.y     (y_s1),
		.z     (z_s1),
		.coefs (cx),
		.res   (x_out)
	);

	pdr_row u_row_y (
		.clk   (clk),
		.ctl   (ctl),
		.x     (x_s1),
		.y     (y_s1),
		.z     (z_s1),
		.coefs (cy),
		.res   (y_out)
	);

	pdr_row u_row_z (
		.clk   (clk),
		.ctl   (ctl),
		.x     (x_s1),
		.y     (y_s1),
		.z     (z_s1),
		.coefs (cz),
		.res   (z_out)
	);

	assign out_valid   = out_valid_q;
	assign payload_out = payload_q;

endmodule

[rtl/pdr_row.sv]
// One row of the 3x3 transform: three products, then sum, round and saturate.
// Depends on pdr_pkg for widths and the stage control struct.
module pdr_row (
	input  logic                                   clk,
	input  pdr_pkg::pdr_ctl_t                      ctl,
	input  logic signed [pdr_pkg::COORD_WIDTH-1:0] x,
	input  logic signed [pdr_pkg::COORD_WIDTH-1:0] y,
	input  logic signed [pdr_pkg::COORD_WIDTH-1:0] z,
	input  logic        [pdr_pkg::ROW_BITS-1:0]    coefs,
	output logic signed [pdr_pkg::COORD_WIDTH-1:0] res
);
	import pdr_pkg::*;

	logic signed [COEF_BITS-1:0] c0, c1, c2;
	logic signed [PROD_BITS-1:0] p0, p1, p2;
	logic signed [PROD_BITS-1:0] p0_s2, p1_s2, p2_s2;
	logic signed [SUM_BITS-1:0]  sum;
	logic signed [SUM_BITS-1:0]  biased;
	logic signed [RND_BITS-1:0]  rnd;
	logic signed [COORD_WIDTH-1:0] sat;
	logic signed [COORD_WIDTH-1:0] res_q;

	assign c0 = coefs[COEF_BITS-1:0];
	assign c1 = coefs[2*COEF_BITS-1:COEF_BITS];
	assign c2 = coefs[3*COEF_BITS-1:2*COEF_BITS];

	assign p0 = x * c0;
	assign p1 = y * c1;
	assign p2 = z * c2;

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			p0_s2 <= p0;
			p1_s2 <= p1;
			p2_s2 <= p2;
		end
	end

	// Adding half an LSB and dropping the fraction bits floors the value,
	// so ties round toward positive infinity.
	assign sum    = SUM_BITS'(p0_s2) + SUM_BITS'(p1_s2) + SUM_BITS'(p2_s2);
	assign biased = sum + SUM_BITS'(1 << (FRAC_BITS - 1));
	assign rnd    = biased[SUM_BITS-1:FRAC_BITS];

	always_comb begin
		if ((&rnd[RND_BITS-1:COORD_WIDTH-1]) || !(|rnd[RND_BITS-1:COORD_WIDTH-1])) begin
			sat = rnd[COORD_WIDTH-1:0];
		end else if (rnd[RND_BITS-1]) begin
			sat = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			sat = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			res_q <= sat;
		end
	end

	assign res = res_q;

endmodule

[rtl/pdr_checker.sv]
// Port-level checks for point_decimate_rotate, attached by the bind below.
// Depends on pdr_pkg for port widths.
module pdr_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_stall,
	input logic                                   out_valid,
	input logic                                   out_stall,
	input logic signed [pdr_pkg::COORD_WIDTH-1:0] x_out,
	input logic signed [pdr_pkg::COORD_WIDTH-1:0] y_out,
	input logic signed [pdr_pkg::COORD_WIDTH-1:0] z_out,
	input logic [pdr_pkg::PAYLOAD_WIDTH-1:0]      payload_out
);
	import pdr_pkg::*;

	// The input side backs up only when the output register is full and stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled output");

	// A result leaves only through a transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(!out_stall))
		else $error("out_valid dropped without a transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("out_valid dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> ($stable(x_out) && $stable(y_out) &&
			$stable(z_out) && $stable(payload_out)))
		else $error("stalled result changed");

endmodule

bind point_decimate_rotate pdr_checker u_pdr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.x_out       (x_out),
	.y_out       (y_out),
	.z_out       (z_out),
	.payload_out (payload_out)
);
